// ----- hdl/egpv_pkg.sv -----
// types, constants and helper functions for the encoder position/velocity core
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package egpv_pkg;

    localparam int COUNT_BITS = 16;
    localparam int REG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int BIG_W      = 96;
    localparam int DEN_W      = 61;
    localparam int REM_W      = 62;
    localparam int QUO_STEPS  = 32;
    localparam int CNT_W      = $clog2(QUO_STEPS);

    // 2*pi in Q3.29, and the same scaled by one million for velocity
    localparam logic [31:0] TWO_PI_Q29 = 32'hC90FDAA2;
    localparam logic [63:0] VEL_K      = 64'd3373259426000000;

    localparam logic [1:0] MODE_PERIODIC = 2'd0;
    localparam logic [1:0] MODE_BOUNDED  = 2'd1;
    localparam logic [1:0] MODE_DUAL     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_P_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_P_NUM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_P_DEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_S_TICKS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_S_NUM   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_S_DEN   = 3'd6;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_DP,
        ST_MUL_MP,
        ST_MUL_DS,
        ST_MUL_MS,
        ST_MUL_VD,
        ST_UPDATE,
        ST_MUL_PN,
        ST_CAP_PN,
        ST_POS_LO,
        ST_POS_HI,
        ST_POS_ACC,
        ST_POS_LOAD,
        ST_POS_DIV,
        ST_POS_END,
        ST_VEL_LO,
        ST_VEL_HI,
        ST_VEL_ACC,
        ST_VEL_LOAD,
        ST_VEL_DIV,
        ST_FINISH
    } t_state;

    typedef enum logic [3:0] {
        MS_NONE,
        MS_DP,
        MS_MP,
        MS_DS,
        MS_MS,
        MS_VD,
        MS_PN,
        MS_PLO,
        MS_PHI,
        MS_VLO,
        MS_VHI
    } t_mul_sel;

    typedef enum logic [3:0] {
        CS_NONE,
        CS_DP,
        CS_MP,
        CS_DS,
        CS_MS,
        CS_VD,
        CS_PN,
        CS_BLO,
        CS_BHI
    } t_cap_sel;

    typedef struct packed {
        logic     in_ready;
        logic     load;
        t_mul_sel mul_sel;
        t_cap_sel cap_sel;
        logic     update;
        logic     div_load;
        logic     div_step;
        logic     div_vel;
        logic     pos_store;
        logic     finish;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } t_stat;

    function automatic logic [REG_W-1:0] f_nz(input logic [REG_W-1:0] v);
        return (v == '0) ? REG_W'(1) : v;
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [34:0] v);
        logic signed [34:0] hi;
        logic signed [34:0] lo;
        hi = 35'sh0_7FFF_FFFF;
        lo = -35'sh0_8000_0000;
        if (v > hi) return 32'sh7FFF_FFFF;
        if (v < lo) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // accumulate a signed step, then pull back into [0, m) once
    function automatic logic signed [31:0] f_wrap_acc(
        input logic signed [31:0] acc,
        input logic [31:0]        mag,
        input logic               neg,
        input logic [31:0]        m
    );
        logic signed [34:0] dv;
        logic signed [34:0] mm;
        logic signed [34:0] s;
        dv = $signed({3'b000, mag});
        if (neg) dv = -dv;
        mm = $signed({3'b000, m});
        s  = 35'(acc) + dv;
        if (s >= mm) s = s - mm;
        else if (s < 0) s = s + mm;
        return f_sat32(s);
    endfunction

    function automatic logic signed [31:0] f_sat_quot(
        input logic [31:0] q,
        input logic        over,
        input logic        neg
    );
        logic [31:0] limit;
        logic [31:0] mag;
        limit = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        mag   = (over || (q > limit)) ? limit : q;
        return neg ? $signed(-mag) : $signed(mag);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/egpv_if.sv -----
// handshake channel interfaces: configuration writes, input samples, results
// depends on egpv_pkg
`timescale 1ns / 1ps
`default_nettype none

interface egpv_cfg_if;
    import egpv_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [REG_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface egpv_in_if;
    import egpv_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] primary_count;
    logic [COUNT_BITS-1:0] secondary_count;
    logic [15:0]           step_time_us;
    modport source (output valid, primary_count, secondary_count, step_time_us,
                    input ready);
    modport sink   (input valid, primary_count, secondary_count, step_time_us,
                    output ready);
endinterface

interface egpv_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position_rad;
    logic signed [31:0] velocity_rad_s;
    logic               is_periodic;
    modport source (output valid, position_rad, velocity_rad_s, is_periodic,
                    input ready);
    modport sink   (input valid, position_rad, velocity_rad_s, is_periodic,
                    output ready);
endinterface

`default_nettype wire

// ----- hdl/egpv_ctrl.sv -----
// sequencer for the estimator: steps the shared multiplier and the serial divider
// depends on egpv_pkg
`timescale 1ns / 1ps
`default_nettype none

module egpv_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire egpv_pkg::t_stat i_stat,
    output egpv_pkg::t_cmd      o_cmd
);
    import egpv_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             cnt_last;

    assign cnt_last = (r_cnt == CNT_W'(QUO_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE:     if (i_stat.in_valid) n_state = ST_MUL_DP;
            ST_MUL_DP:   n_state = ST_MUL_MP;
            ST_MUL_MP:   n_state = ST_MUL_DS;
            ST_MUL_DS:   n_state = ST_MUL_MS;
            ST_MUL_MS:   n_state = ST_MUL_VD;
            ST_MUL_VD:   n_state = ST_UPDATE;
            ST_UPDATE:   n_state = ST_MUL_PN;
            ST_MUL_PN:   n_state = ST_CAP_PN;
            ST_CAP_PN:   n_state = ST_POS_LO;
            ST_POS_LO:   n_state = ST_POS_HI;
            ST_POS_HI:   n_state = ST_POS_ACC;
            ST_POS_ACC:  n_state = ST_POS_LOAD;
            ST_POS_LOAD: begin
                n_state = ST_POS_DIV;
                n_cnt   = '0;
            end
            ST_POS_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (cnt_last) n_state = ST_POS_END;
            end
            ST_POS_END:  n_state = ST_VEL_LO;
            ST_VEL_LO:   n_state = ST_VEL_HI;
            ST_VEL_HI:   n_state = ST_VEL_ACC;
            ST_VEL_ACC:  n_state = ST_VEL_LOAD;
            ST_VEL_LOAD: begin
                n_state = ST_VEL_DIV;
                n_cnt   = '0;
            end
            ST_VEL_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (cnt_last) n_state = ST_FINISH;
            end
            ST_FINISH:   if (i_stat.out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = MS_NONE;
        o_cmd.cap_sel = CS_NONE;
        case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.load     = i_stat.in_valid;
            end
            ST_MUL_DP:   o_cmd.mul_sel = MS_DP;
            ST_MUL_MP: begin
                o_cmd.cap_sel = CS_DP;
                o_cmd.mul_sel = MS_MP;
            end
            ST_MUL_DS: begin
                o_cmd.cap_sel = CS_MP;
                o_cmd.mul_sel = MS_DS;
            end
            ST_MUL_MS: begin
                o_cmd.cap_sel = CS_DS;
                o_cmd.mul_sel = MS_MS;
            end
            ST_MUL_VD: begin
                o_cmd.cap_sel = CS_MS;
                o_cmd.mul_sel = MS_VD;
            end
            ST_UPDATE: begin
                o_cmd.cap_sel = CS_VD;
                o_cmd.update  = 1'b1;
            end
            ST_MUL_PN:   o_cmd.mul_sel = MS_PN;
            ST_CAP_PN:   o_cmd.cap_sel = CS_PN;
            ST_POS_LO:   o_cmd.mul_sel = MS_PLO;
            ST_POS_HI: begin
                o_cmd.cap_sel = CS_BLO;
                o_cmd.mul_sel = MS_PHI;
            end
            ST_POS_ACC:  o_cmd.cap_sel = CS_BHI;
            ST_POS_LOAD: o_cmd.div_load = 1'b1;
            ST_POS_DIV:  o_cmd.div_step = 1'b1;
            ST_POS_END:  o_cmd.pos_store = 1'b1;
            ST_VEL_LO: begin
                o_cmd.div_vel = 1'b1;
                o_cmd.mul_sel = MS_VLO;
            end
            ST_VEL_HI: begin
                o_cmd.div_vel = 1'b1;
                o_cmd.cap_sel = CS_BLO;
                o_cmd.mul_sel = MS_VHI;
            end
            ST_VEL_ACC: begin
                o_cmd.div_vel = 1'b1;
                o_cmd.cap_sel = CS_BHI;
            end
            ST_VEL_LOAD: begin
                o_cmd.div_vel  = 1'b1;
                o_cmd.div_load = 1'b1;
            end
            ST_VEL_DIV: begin
                o_cmd.div_vel  = 1'b1;
                o_cmd.div_step = 1'b1;
            end
            ST_FINISH: begin
                o_cmd.div_vel = 1'b1;
                o_cmd.finish  = i_stat.out_free;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/egpv_dp.sv -----
// datapath: config registers, encoder state, shared 32x32 multiplier,
// restoring divider and output register; depends on egpv_pkg and egpv_if
`timescale 1ns / 1ps
`default_nettype none

module egpv_dp (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    egpv_cfg_if.sink             i_cfg,
    egpv_in_if.sink              i_in,
    egpv_out_if.source           o_out,
    input  wire egpv_pkg::t_cmd  i_cmd,
    output egpv_pkg::t_stat      o_stat
);
    import egpv_pkg::*;

    // configuration
    logic [1:0]       r_mode;
    logic [REG_W-1:0] r_p_ticks, r_p_num, r_p_den;
    logic [REG_W-1:0] r_s_ticks, r_s_num, r_s_den;

    // encoder state
    logic [COUNT_BITS-1:0] r_pl, r_sl;
    logic signed [31:0]    r_pa, r_sa;

    // per-transaction working registers
    logic [COUNT_BITS-1:0] r_dmag_p, r_dmag_s;
    logic                  r_vneg, r_sneg, r_pneg;
    logic [15:0]           r_dt;
    logic [31:0]           r_vmag, r_smag, r_mp, r_ms;
    logic [DEN_W-1:0]      r_velden;
    logic [47:0]           r_pnmag;
    logic [63:0]           r_prod;
    logic [BIG_W-1:0]      r_big;
    logic [REM_W-1:0]      r_rem;
    logic [31:0]           r_quo;
    logic                  r_over;
    logic signed [31:0]    r_pos;

    // result register
    logic                  r_out_valid;
    logic signed [31:0]    r_out_pos, r_out_vel;
    logic                  r_out_per;

    logic                  is_bounded, is_dual;
    logic [COUNT_BITS-1:0] diff_p, diff_s;
    logic [31:0]           mul_a, mul_b;
    logic signed [31:0]    acc_sel;
    logic [DEN_W-1:0]      den;
    logic [REM_W-1:0]      trial;
    logic signed [31:0]    quot_res;
    logic signed [34:0]    bnd_sum;

    assign is_bounded = (r_mode == MODE_BOUNDED);
    assign is_dual    = (r_mode == MODE_DUAL);

    assign diff_p = i_in.primary_count - r_pl;
    assign diff_s = i_in.secondary_count - r_sl;

    assign acc_sel = is_dual ? r_sa : r_pa;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = i_cmd.in_ready;

    assign o_stat.in_valid = i_in.valid;
    assign o_stat.out_free = !r_out_valid || o_out.ready;

    assign o_out.valid          = r_out_valid;
    assign o_out.position_rad   = r_out_pos;
    assign o_out.velocity_rad_s = r_out_vel;
    assign o_out.is_periodic    = r_out_per;

    // shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_sel)
            MS_DP: begin
                mul_a = 32'(r_dmag_p);
                mul_b = 32'(f_nz(r_p_num));
            end
            MS_MP: begin
                mul_a = 32'(f_nz(r_p_ticks));
                mul_b = 32'(f_nz(r_p_den));
            end
            MS_DS: begin
                mul_a = 32'(r_dmag_s);
                mul_b = 32'(f_nz(r_s_num));
            end
            MS_MS: begin
                mul_a = 32'(f_nz(r_s_ticks));
                mul_b = 32'(f_nz(r_s_den));
            end
            MS_VD: begin
                mul_a = r_mp;
                mul_b = 32'(r_dt);
            end
            MS_PN: begin
                // magnitude of the position numerator; times p only when bounded
                mul_a = acc_sel[31] ? -acc_sel : acc_sel;
                mul_b = is_bounded ? 32'(f_nz(r_p_num)) : 32'd1;
            end
            MS_PLO: begin
                mul_a = r_pnmag[31:0];
                mul_b = TWO_PI_Q29;
            end
            MS_PHI: begin
                mul_a = 32'(r_pnmag[47:32]);
                mul_b = TWO_PI_Q29;
            end
            MS_VLO: begin
                mul_a = r_vmag;
                mul_b = VEL_K[31:0];
            end
            MS_VHI: begin
                mul_a = r_vmag;
                mul_b = VEL_K[63:32];
            end
            default: ;
        endcase
    end

    assign den     = i_cmd.div_vel ? r_velden : DEN_W'({r_ms, 13'b0}) ;
    assign trial   = {r_rem[REM_W-2:0], r_big[31]};
    assign bnd_sum = 35'(r_pa) + (r_vneg ? -35'(r_dmag_p) : 35'(r_dmag_p));
    assign quot_res = f_sat_quot(r_quo, r_over, i_cmd.div_vel ? r_vneg : r_pneg);

    // configuration and encoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_PERIODIC;
            r_p_ticks <= REG_W'(1);
            r_p_num   <= REG_W'(1);
            r_p_den   <= REG_W'(1);
            r_s_ticks <= REG_W'(1);
            r_s_num   <= REG_W'(1);
            r_s_den   <= REG_W'(1);
            r_pl      <= '0;
            r_sl      <= '0;
            r_pa      <= '0;
            r_sa      <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_MODE:    r_mode    <= i_cfg.data[1:0];
                    REG_P_TICKS: r_p_ticks <= i_cfg.data;
                    REG_P_NUM:   r_p_num   <= i_cfg.data;
                    REG_P_DEN:   r_p_den   <= i_cfg.data;
                    REG_S_TICKS: r_s_ticks <= i_cfg.data;
                    REG_S_NUM:   r_s_num   <= i_cfg.data;
                    REG_S_DEN:   r_s_den   <= i_cfg.data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_pl <= i_in.primary_count;
                if (is_dual) r_sl <= i_in.secondary_count;
            end
            if (i_cmd.update) begin
                if (is_bounded) begin
                    r_pa <= f_sat32(bnd_sum);
                end else begin
                    r_pa <= f_wrap_acc(r_pa, r_vmag, r_vneg, r_mp);
                    if (is_dual) r_sa <= f_wrap_acc(r_sa, r_smag, r_sneg, r_ms);
                end
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dmag_p <= diff_p[COUNT_BITS-1] ? -diff_p : diff_p;
            r_vneg   <= diff_p[COUNT_BITS-1];
            r_dmag_s <= diff_s[COUNT_BITS-1] ? -diff_s : diff_s;
            r_sneg   <= diff_s[COUNT_BITS-1];
            r_dt     <= f_nz(i_in.step_time_us);
        end
        r_prod <= mul_a * mul_b;
        case (i_cmd.cap_sel)
            CS_DP:  r_vmag   <= r_prod[31:0];
            CS_MP:  r_mp     <= r_prod[31:0];
            CS_DS:  r_smag   <= r_prod[31:0];
            CS_MS: begin
                // position denominator defaults to the primary one
                r_ms <= is_dual ? r_prod[31:0] : r_mp;
            end
            CS_VD:  r_velden <= {r_prod[47:0], 13'b0};
            CS_PN: begin
                r_pnmag <= r_prod[47:0];
                r_pneg  <= acc_sel[31];
            end
            CS_BLO: r_big <= BIG_W'(r_prod);
            CS_BHI: r_big <= r_big + {r_prod, 32'b0};
            default: ;
        endcase
        if (i_cmd.div_load) begin
            // quotient can only exceed 32 bits when the top part reaches den
            r_over <= (r_big[BIG_W-1:32] >= 64'(den));
            r_rem  <= r_big[REM_W+31:32];
            r_quo  <= '0;
        end else if (i_cmd.div_step) begin
            r_big <= {r_big[BIG_W-2:0], 1'b0};
            if (trial >= REM_W'(den)) begin
                r_rem <= trial - REM_W'(den);
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= trial;
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
        if (i_cmd.pos_store) r_pos <= quot_res;
        if (i_cmd.finish) begin
            r_out_pos <= r_pos;
            r_out_vel <= quot_res;
            r_out_per <= !is_bounded;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/encoder_gear_position_velocity_core.sv -----
// top level of the gear-aware encoder position and velocity estimator
// depends on egpv_pkg, egpv_if, egpv_ctrl and egpv_dp
`timescale 1ns / 1ps
`default_nettype none

// Each input transaction carries two raw encoder counts and the step time; it
// yields one result with position and velocity in signed Q16.16 (rad, rad/s),
// both saturated, plus a flag that tells whether position wraps per output
// revolution. On the way from acceptance to the result register, a shared
// 32x32 multiplier forms the products in turn and a one-bit-per-cycle
// restoring divider runs 32 steps for position and 32 for velocity. A new
// sample is accepted once the previous one has reached the result register,
// so a waiting result does not block the next sample.
// Configuration writes are always ready and take effect at once.
module encoder_gear_position_velocity_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    egpv_cfg_if.sink   i_cfg,
    egpv_in_if.sink    i_in,
    egpv_out_if.source o_out
);
    import egpv_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    egpv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    egpv_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

endmodule

`default_nettype wire
